// ===== sv/etfp_pkg.sv =====
// Shared types and constants for the escape-time fractal pixel evaluator.
// Used by the channel interfaces file and the top level; depends on nothing.
package etfp_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER_RE   = 3'd0,
        REG_CENTER_IM   = 3'd1,
        REG_STEP_RE     = 3'd2,
        REG_STEP_IM     = 3'd3,
        REG_HALF_WIDTH  = 3'd4,
        REG_HALF_HEIGHT = 3'd5,
        REG_MAX_ITER    = 3'd6
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int WORD_W      = 32;
    localparam int STEP_W      = 31;
    localparam int HALF_W      = 12;
    localparam int ITER_W      = 10;
    localparam int PROD_W      = 64;

    // Register reset values
    localparam logic [WORD_W-1:0] CENTER_RE_RST   = 32'hF400_0000;
    localparam logic [WORD_W-1:0] CENTER_IM_RST   = 32'h0800_0000;
    localparam logic [STEP_W-1:0] STEP_RE_RST     = 31'd419430;
    localparam logic [STEP_W-1:0] STEP_IM_RST     = 31'd497102;
    localparam logic [HALF_W-1:0] HALF_WIDTH_RST  = 12'd960;
    localparam logic [HALF_W-1:0] HALF_HEIGHT_RST = 12'd540;
    localparam logic [ITER_W-1:0] MAX_ITER_RST    = 10'd128;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_CRE  = 9'b0_0000_0010,
        S_CIM  = 9'b0_0000_0100,
        S_CADD = 9'b0_0000_1000,
        S_NEW  = 9'b0_0001_0000,
        S_SQRE = 9'b0_0010_0000,
        S_SQIM = 9'b0_0100_0000,
        S_MAG  = 9'b0_1000_0000,
        S_DONE = 9'b1_0000_0000
    } state_t;

    // True when a 64-bit value lies in the signed 32-bit range
    function automatic logic fits_word(input logic [PROD_W-1:0] v);
        return (v[PROD_W-1:WORD_W-1] == '0) || (v[PROD_W-1:WORD_W-1] == '1);
    endfunction

endpackage

// ===== sv/etfp_ifs.sv =====
// Valid/ready channel interfaces for pixel coordinates and iteration results.
// Depends on etfp_pkg for field widths.
interface etfp_pixel_if #(
    parameter int COORD_W = 12
);
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface etfp_result_if;
    logic                         valid;
    logic                         ready;
    logic [etfp_pkg::ITER_W-1:0]  iteration_count;
    logic                         inside_res;

    modport source (output valid, output iteration_count, output inside_res, input ready);
    modport sink   (input valid, input iteration_count, input inside_res, output ready);
endinterface

// ===== sv/escape_time_fractal_pixel.sv =====
// Escape-time fractal pixel evaluator: one shared 32x32 multiplier under a sequencer.
// Depends on etfp_pkg and the channel interfaces in etfp_ifs.sv.
//
//  channel | dir | beat payload                     | handshake
//  --------+-----+----------------------------------+------------------
//  pix     | in  | pixel_x, pixel_y                 | valid / ready
//  res     | out | iteration_count, inside_res      | valid / ready
//  cfg     | in  | cfg_index, cfg_data              | cfg_we, no wait
//
// A pixel forms c in S_CRE, S_CIM and S_CADD, then each iteration runs S_NEW,
// S_SQRE, S_SQIM and S_MAG: the single multiplier forms re*im, re*re and im*im in
// turn, each product registered. At most max_iter iterations are run per pixel.
// Reset clears the sequencer and output valid and loads the register defaults.
// A finished result waits in the output register; the next pixel is taken
// meanwhile, and the sequencer holds its result only if that register is full.
module escape_time_fractal_pixel #(
    parameter int FRACTION_BITS    = 28,
    parameter int PIXEL_COORD_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [etfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [etfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    etfp_pixel_if.sink                        pix,
    etfp_result_if.source                     res
);

    localparam int WORD_W = etfp_pkg::WORD_W;
    localparam int PROD_W = etfp_pkg::PROD_W;
    localparam int ITER_W = etfp_pkg::ITER_W;
    localparam int HALF_W = etfp_pkg::HALF_W;
    localparam int STEP_W = etfp_pkg::STEP_W;
    // Pixel offset from center, signed
    localparam int DIFF_W = ((PIXEL_COORD_BITS > HALF_W) ? PIXEL_COORD_BITS : HALF_W) + 1;
    // Point c: center plus offset times step
    localparam int C_W    = DIFF_W + STEP_W + 2;
    // New z before the range check
    localparam int N_W    = C_W + 2;
    localparam logic signed [PROD_W-1:0] BOUND = 64'sd4 <<< FRACTION_BITS;

    // Configuration registers
    logic [WORD_W-1:0] center_re_reg, center_im_reg;
    logic [STEP_W-1:0] step_re_reg, step_im_reg;
    logic [HALF_W-1:0] half_width_reg, half_height_reg;
    logic [ITER_W-1:0] max_iter_reg;

    // Sequencer and datapath
    etfp_pkg::state_t state_reg, state_next;
    logic [PIXEL_COORD_BITS-1:0] px_reg, py_reg;
    logic signed [PROD_W-1:0]    p_reg;
    logic signed [C_W-1:0]       c_re_reg, c_re_next;
    logic signed [C_W-1:0]       c_im_reg, c_im_next;
    logic signed [WORD_W-1:0]    re_reg, re_next, im_reg, im_next;
    logic signed [WORD_W-1:0]    rr_reg, rr_next, ii_reg, ii_next;
    logic [ITER_W-1:0]           iter_reg, iter_next;
    logic [ITER_W-1:0]           cnt_reg, cnt_next;
    logic                        inside_reg, inside_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [ITER_W-1:0] out_count_reg;
    logic              out_inside_reg;
    logic              out_load;

    logic signed [WORD_W-1:0] op_a, op_b;
    logic signed [DIFF_W-1:0] diff_x, diff_y;
    logic signed [PROD_W-1:0] sq_shift, ri_shift;
    logic signed [N_W-1:0]    nre, nim;
    logic signed [WORD_W:0]   mag;
    logic [ITER_W:0]          iter_inc;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_re_reg   <= etfp_pkg::CENTER_RE_RST;
            center_im_reg   <= etfp_pkg::CENTER_IM_RST;
            step_re_reg     <= etfp_pkg::STEP_RE_RST;
            step_im_reg     <= etfp_pkg::STEP_IM_RST;
            half_width_reg  <= etfp_pkg::HALF_WIDTH_RST;
            half_height_reg <= etfp_pkg::HALF_HEIGHT_RST;
            max_iter_reg    <= etfp_pkg::MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                etfp_pkg::REG_CENTER_RE:   center_re_reg   <= cfg_data;
                etfp_pkg::REG_CENTER_IM:   center_im_reg   <= cfg_data;
                etfp_pkg::REG_STEP_RE:     step_re_reg     <= cfg_data[STEP_W-1:0];
                etfp_pkg::REG_STEP_IM:     step_im_reg     <= cfg_data[STEP_W-1:0];
                etfp_pkg::REG_HALF_WIDTH:  half_width_reg  <= cfg_data[HALF_W-1:0];
                etfp_pkg::REG_HALF_HEIGHT: half_height_reg <= cfg_data[HALF_W-1:0];
                etfp_pkg::REG_MAX_ITER:    max_iter_reg    <= cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // Pixel offsets from the view center
    assign diff_x = DIFF_W'($signed({1'b0, px_reg})) - DIFF_W'($signed({1'b0, half_width_reg}));
    assign diff_y = DIFF_W'($signed({1'b0, py_reg})) - DIFF_W'($signed({1'b0, half_height_reg}));

    // Select multiplier operands by state
    always_comb
    begin
        unique case (state_reg)
            etfp_pkg::S_CRE:
            begin
                op_a = WORD_W'(diff_x);
                op_b = $signed({1'b0, step_re_reg});
            end
            etfp_pkg::S_CIM:
            begin
                op_a = WORD_W'(diff_y);
                op_b = $signed({1'b0, step_im_reg});
            end
            etfp_pkg::S_SQRE:
            begin
                op_a = re_reg;
                op_b = re_reg;
            end
            etfp_pkg::S_SQIM:
            begin
                op_a = im_reg;
                op_b = im_reg;
            end
            default:
            begin
                op_a = re_reg;
                op_b = im_reg;
            end
        endcase
    end

    // Shared multiplier, registered product
    always_ff @(posedge clk)
    begin
        p_reg <= op_a * op_b;
    end

    // Truncate products and form the next z and magnitude
    assign sq_shift = p_reg >>> FRACTION_BITS;
    assign ri_shift = p_reg >>> (FRACTION_BITS - 1);
    assign nre      = N_W'(rr_reg) - N_W'(ii_reg) + N_W'(c_re_reg);
    assign nim      = N_W'($signed(ri_shift[WORD_W-1:0])) + N_W'(c_im_reg);
    assign mag      = (WORD_W+1)'(rr_reg) + (WORD_W+1)'(sq_shift[WORD_W-1:0]);
    assign iter_inc = {1'b0, iter_reg} + (ITER_W+1)'(1);

    assign out_load = (state_reg == etfp_pkg::S_DONE) && (!out_valid_reg || res.ready);

    // Sequence one pixel through c and the iterations
    always_comb
    begin
        state_next  = state_reg;
        c_re_next   = c_re_reg;
        c_im_next   = c_im_reg;
        re_next     = re_reg;
        im_next     = im_reg;
        rr_next     = rr_reg;
        ii_next     = ii_reg;
        iter_next   = iter_reg;
        cnt_next    = cnt_reg;
        inside_next = inside_reg;
        unique case (state_reg)
            etfp_pkg::S_IDLE:
            begin
                if (pix.valid)
                begin
                    state_next = etfp_pkg::S_CRE;
                end
            end
            etfp_pkg::S_CRE:
            begin
                state_next = etfp_pkg::S_CIM;
            end
            etfp_pkg::S_CIM:
            begin
                c_re_next  = C_W'($signed(center_re_reg)) + p_reg[C_W-1:0];
                re_next    = '0;
                im_next    = '0;
                rr_next    = '0;
                ii_next    = '0;
                iter_next  = '0;
                state_next = etfp_pkg::S_CADD;
            end
            etfp_pkg::S_CADD:
            begin
                c_im_next = C_W'($signed(center_im_reg)) + p_reg[C_W-1:0];
                if (max_iter_reg == '0)
                begin
                    cnt_next    = '0;
                    inside_next = 1'b1;
                    state_next  = etfp_pkg::S_DONE;
                end
                else
                begin
                    state_next = etfp_pkg::S_NEW;
                end
            end
            etfp_pkg::S_NEW:
            begin
                // p_reg holds re*im of the current z
                if (!etfp_pkg::fits_word(ri_shift) ||
                    !etfp_pkg::fits_word(PROD_W'(nre)) ||
                    !etfp_pkg::fits_word(PROD_W'(nim)))
                begin
                    cnt_next    = iter_reg;
                    inside_next = 1'b0;
                    state_next  = etfp_pkg::S_DONE;
                end
                else
                begin
                    re_next    = nre[WORD_W-1:0];
                    im_next    = nim[WORD_W-1:0];
                    state_next = etfp_pkg::S_SQRE;
                end
            end
            etfp_pkg::S_SQRE:
            begin
                state_next = etfp_pkg::S_SQIM;
            end
            etfp_pkg::S_SQIM:
            begin
                // p_reg holds re*re; the next cycle finishes the magnitude
                rr_next = sq_shift[WORD_W-1:0];
                if (!etfp_pkg::fits_word(sq_shift))
                begin
                    cnt_next    = iter_reg;
                    inside_next = 1'b0;
                    state_next  = etfp_pkg::S_DONE;
                end
                else
                begin
                    state_next = etfp_pkg::S_MAG;
                end
            end
            etfp_pkg::S_MAG:
            begin
                // p_reg holds im*im; the multiplier starts re*im meanwhile
                ii_next = sq_shift[WORD_W-1:0];
                if (!etfp_pkg::fits_word(sq_shift) ||
                    (mag[WORD_W] != mag[WORD_W-1]) ||
                    (PROD_W'(mag) > BOUND))
                begin
                    cnt_next    = iter_reg;
                    inside_next = 1'b0;
                    state_next  = etfp_pkg::S_DONE;
                end
                else if (iter_inc == {1'b0, max_iter_reg})
                begin
                    cnt_next    = max_iter_reg;
                    inside_next = 1'b1;
                    state_next  = etfp_pkg::S_DONE;
                end
                else
                begin
                    iter_next  = iter_inc[ITER_W-1:0];
                    state_next = etfp_pkg::S_NEW;
                end
            end
            etfp_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = etfp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = etfp_pkg::S_IDLE;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= etfp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Hold datapath values
    always_ff @(posedge clk)
    begin
        if ((state_reg == etfp_pkg::S_IDLE) && pix.valid)
        begin
            px_reg <= pix.pixel_x;
            py_reg <= pix.pixel_y;
        end
        c_re_reg   <= c_re_next;
        c_im_reg   <= c_im_next;
        re_reg     <= re_next;
        im_reg     <= im_next;
        rr_reg     <= rr_next;
        ii_reg     <= ii_next;
        iter_reg   <= iter_next;
        cnt_reg    <= cnt_next;
        inside_reg <= inside_next;
    end

    // Result beat register
    assign out_valid_next = (out_valid_reg && !res.ready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_count_reg  <= cnt_reg;
            out_inside_reg <= inside_reg;
        end
    end

    assign pix.ready           = (state_reg == etfp_pkg::S_IDLE);
    assign res.valid           = out_valid_reg;
    assign res.iteration_count = out_count_reg;
    assign res.inside_res      = out_inside_reg;

endmodule
